@@ sv/vgbs_pkg.sv @@
package vgbs_pkg;

  // action codes
  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_SAMPLE = 2'd2;
  localparam logic [1:0] ACT_CLEAR  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_OOB   = 2'd2;

  // register indexes
  localparam logic [7:0] REG_WIDTH  = 8'd0;
  localparam logic [7:0] REG_HEIGHT = 8'd1;

  localparam logic [7:0] SIZE_RESET = 8'd128;

  // width of the linear cell index before trimming to the store depth
  localparam int IDX_W = 18;

  // which neighbor cell an address refers to
  typedef enum logic [1:0] {
    SEL_A,
    SEL_B,
    SEL_C,
    SEL_D
  } addr_sel_t;

  // step of the shared blend unit
  typedef enum logic [2:0] {
    LS_TOPX,
    LS_TOPY,
    LS_BOTX,
    LS_BOTY,
    LS_RX,
    LS_RY
  } lerp_step_t;

  // how the result registers are set
  typedef enum logic [2:0] {
    RES_NONE,
    RES_OK,
    RES_EMPTY,
    RES_OOB,
    RES_READ
  } res_op_t;

  typedef struct packed {
    logic       load_in;
    logic       prep;
    logic       mem_wr;
    logic       rd_en;
    addr_sel_t  addr_sel;
    logic       clr_start;
    logic       clr_step;
    logic       lerp_en;
    lerp_step_t lerp_step;
    res_op_t    res_op;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       empty;
    logic       oob;
    logic       clr_last;
    logic       out_free;
  } sts_t;

endpackage

@@ sv/vgbs_ctrl.sv @@
module vgbs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  vgbs_pkg::sts_t sts,
  output vgbs_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_PREP,
    S_EXEC,
    S_RD1,
    S_RD2,
    S_RD3,
    S_RDW,
    S_RDDONE,
    S_L1,
    S_L2,
    S_L3,
    S_L4,
    S_L5,
    S_L6,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   clr_reply;
  logic   clr_reply_next;

  assign in_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next     = state;
    clr_reply_next = clr_reply;
    cmd            = '0;
    cmd.addr_sel   = vgbs_pkg::SEL_A;
    cmd.lerp_step  = vgbs_pkg::LS_TOPX;
    cmd.res_op     = vgbs_pkg::RES_NONE;
    case (state)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = clr_reply ? S_FIN : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (sts.act == vgbs_pkg::ACT_CLEAR) begin
          cmd.clr_start  = 1'b1;
          cmd.res_op     = vgbs_pkg::RES_OK;
          clr_reply_next = 1'b1;
          state_next     = S_CLR;
        end else if (sts.empty) begin
          cmd.res_op = vgbs_pkg::RES_EMPTY;
          state_next = S_FIN;
        end else if (sts.act != vgbs_pkg::ACT_SAMPLE && sts.oob) begin
          cmd.res_op = vgbs_pkg::RES_OOB;
          state_next = S_FIN;
        end else if (sts.act == vgbs_pkg::ACT_WRITE) begin
          cmd.mem_wr = 1'b1;
          cmd.res_op = vgbs_pkg::RES_OK;
          state_next = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = (sts.act == vgbs_pkg::ACT_SAMPLE) ? S_RD1 : S_RDW;
        end
      end
      S_RD1: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = vgbs_pkg::SEL_B;
        state_next   = S_RD2;
      end
      S_RD2: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = vgbs_pkg::SEL_C;
        state_next   = S_RD3;
      end
      S_RD3: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = vgbs_pkg::SEL_D;
        state_next   = S_RDW;
      end
      S_RDW: begin
        state_next = (sts.act == vgbs_pkg::ACT_SAMPLE) ? S_L1 : S_RDDONE;
      end
      S_RDDONE: begin
        cmd.res_op = vgbs_pkg::RES_READ;
        state_next = S_FIN;
      end
      S_L1: begin
        cmd.lerp_en   = 1'b1;
        cmd.lerp_step = vgbs_pkg::LS_TOPX;
        state_next    = S_L2;
      end
      S_L2: begin
        cmd.lerp_en   = 1'b1;
        cmd.lerp_step = vgbs_pkg::LS_TOPY;
        state_next    = S_L3;
      end
      S_L3: begin
        cmd.lerp_en   = 1'b1;
        cmd.lerp_step = vgbs_pkg::LS_BOTX;
        state_next    = S_L4;
      end
      S_L4: begin
        cmd.lerp_en   = 1'b1;
        cmd.lerp_step = vgbs_pkg::LS_BOTY;
        state_next    = S_L5;
      end
      S_L5: begin
        cmd.lerp_en   = 1'b1;
        cmd.lerp_step = vgbs_pkg::LS_RX;
        state_next    = S_L6;
      end
      S_L6: begin
        cmd.lerp_en   = 1'b1;
        cmd.lerp_step = vgbs_pkg::LS_RY;
        state_next    = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_reply <= 1'b0;
    end else begin
      state     <= state_next;
      clr_reply <= clr_reply_next;
    end
  end

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in flight");

  a_port_conflict: assert property (@(posedge clk) disable iff (rst)
    !((cmd.mem_wr || cmd.clr_step) && cmd.rd_en))
    else $error("store read and write in one cycle");

  a_reset_sweep: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (in_stall && cmd.clr_step))
    else $error("no clearing sweep after reset");
`endif

endmodule

@@ sv/vgbs_dp.sv @@
module vgbs_dp #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  vgbs_pkg::cmd_t     cmd,
  output vgbs_pkg::sts_t     sts,
  input  logic               cfg_valid,
  input  logic [7:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic [1:0]         action,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [31:0] value_x,
  input  logic signed [31:0] value_y,
  input  logic               out_stall,
  output logic               out_valid,
  output logic signed [31:0] result_x,
  output logic signed [31:0] result_y,
  output logic [1:0]         status
);

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [8:0] MAXW9 = 9'(MAX_WIDTH);
  localparam logic [8:0] MAXH9 = 9'(MAX_HEIGHT);

  logic [7:0]  grid_width;
  logic [7:0]  grid_height;
  logic [8:0]  wu;
  logic [8:0]  hu;

  logic [1:0]         act;
  logic signed [15:0] px;
  logic signed [15:0] py;
  logic [63:0]        wdata_in;

  logic        empty;
  logic        oob;
  logic [7:0]  x0, x1, y0, y1, tx, ty;

  logic [63:0] mem [CELLS];
  logic [63:0] rdata;
  logic        rd_vld;
  vgbs_pkg::addr_sel_t rd_sel;
  logic [63:0] cell_a, cell_b, cell_c, cell_d;

  logic [AW-1:0] clr_addr;

  logic signed [41:0] topx, topy, botx, boty;
  logic signed [31:0] res_x, res_y;
  logic [1:0]         res_st;

  // configuration registers, always ready
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= vgbs_pkg::SIZE_RESET;
      grid_height <= vgbs_pkg::SIZE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == vgbs_pkg::REG_WIDTH) begin
        grid_width <= cfg_data;
      end
      if (cfg_index == vgbs_pkg::REG_HEIGHT) begin
        grid_height <= cfg_data;
      end
    end
  end

  // size in use
  assign wu = ({1'b0, grid_width} > MAXW9) ? MAXW9 : {1'b0, grid_width};
  assign hu = ({1'b0, grid_height} > MAXH9) ? MAXH9 : {1'b0, grid_height};

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act      <= action;
      px       <= pos_x;
      py       <= pos_y;
      wdata_in <= {value_y, value_x};
    end
  end

  // coordinate decode: range check, clamp, neighbor indexes
  logic [8:0]  wm1, hm1;
  logic [15:0] topx_lim, topy_lim, cx, cy;
  logic [8:0]  x0p1, y0p1;
  logic [7:0]  nx0, ny0;
  logic        p_oob;

  always_comb begin
    wm1      = wu - 9'd1;
    hm1      = hu - 9'd1;
    topx_lim = {wm1[7:0], 8'h00};
    topy_lim = {hm1[7:0], 8'h00};
    cx = px[15] ? 16'd0 : ((16'(px) > topx_lim) ? topx_lim : 16'(px));
    cy = py[15] ? 16'd0 : ((16'(py) > topy_lim) ? topy_lim : 16'(py));
    p_oob = px[15] || py[15] || ({2'b00, px[14:8]} >= wu) || ({2'b00, py[14:8]} >= hu);
    if (act == vgbs_pkg::ACT_SAMPLE) begin
      nx0 = cx[15:8];
      ny0 = cy[15:8];
    end else begin
      nx0 = {1'b0, px[14:8]};
      ny0 = {1'b0, py[14:8]};
    end
    x0p1 = {1'b0, nx0} + 9'd1;
    y0p1 = {1'b0, ny0} + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      empty <= (wu == 9'd0) || (hu == 9'd0);
      oob   <= p_oob;
      x0    <= nx0;
      y0    <= ny0;
      x1    <= (x0p1 < wu) ? x0p1[7:0] : wm1[7:0];
      y1    <= (y0p1 < hu) ? y0p1[7:0] : hm1[7:0];
      tx    <= cx[7:0];
      ty    <= cy[7:0];
    end
  end

  // cell address: row times width plus column
  logic [7:0]             ax_sel, ay_sel;
  logic [vgbs_pkg::IDX_W-1:0] lin_idx;
  logic [AW-1:0]          cell_addr;

  always_comb begin
    case (cmd.addr_sel)
      vgbs_pkg::SEL_A: begin ax_sel = x0; ay_sel = y0; end
      vgbs_pkg::SEL_B: begin ax_sel = x1; ay_sel = y0; end
      vgbs_pkg::SEL_C: begin ax_sel = x0; ay_sel = y1; end
      vgbs_pkg::SEL_D: begin ax_sel = x1; ay_sel = y1; end
      default:         begin ax_sel = x0; ay_sel = y0; end
    endcase
    lin_idx = vgbs_pkg::IDX_W'(ay_sel) * vgbs_pkg::IDX_W'(wu)
            + vgbs_pkg::IDX_W'(ax_sel);
    cell_addr = lin_idx[AW-1:0];
  end

  // clear sweep counter
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_start) begin
      clr_addr <= '0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // vector store, one access a cycle
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[clr_addr] <= 64'd0;
    end else if (cmd.mem_wr) begin
      mem[cell_addr] <= wdata_in;
    end
    if (cmd.rd_en) begin
      rdata <= mem[cell_addr];
    end
  end

  // read tag follows the registered read data
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_en;
    end
    rd_sel <= cmd.addr_sel;
  end

  always_ff @(posedge clk) begin
    if (rd_vld) begin
      case (rd_sel)
        vgbs_pkg::SEL_A: cell_a <= rdata;
        vgbs_pkg::SEL_B: cell_b <= rdata;
        vgbs_pkg::SEL_C: cell_c <= rdata;
        vgbs_pkg::SEL_D: cell_d <= rdata;
        default:         cell_a <= rdata;
      endcase
    end
  end

  // shared blend unit: p * (256 - t) + q * t
  logic signed [41:0] lp, lq;
  logic [7:0]         lt;
  logic signed [9:0]  w1, w0;
  logic signed [52:0] lsum;
  logic signed [52:0] lrnd;

  always_comb begin
    case (cmd.lerp_step)
      vgbs_pkg::LS_TOPX: begin
        lp = 42'(signed'(cell_a[31:0]));  lq = 42'(signed'(cell_b[31:0]));  lt = tx;
      end
      vgbs_pkg::LS_TOPY: begin
        lp = 42'(signed'(cell_a[63:32])); lq = 42'(signed'(cell_b[63:32])); lt = tx;
      end
      vgbs_pkg::LS_BOTX: begin
        lp = 42'(signed'(cell_c[31:0]));  lq = 42'(signed'(cell_d[31:0]));  lt = tx;
      end
      vgbs_pkg::LS_BOTY: begin
        lp = 42'(signed'(cell_c[63:32])); lq = 42'(signed'(cell_d[63:32])); lt = tx;
      end
      vgbs_pkg::LS_RX: begin
        lp = topx; lq = botx; lt = ty;
      end
      vgbs_pkg::LS_RY: begin
        lp = topy; lq = boty; lt = ty;
      end
      default: begin
        lp = topx; lq = botx; lt = ty;
      end
    endcase
    w1   = signed'({2'b00, lt});
    w0   = 10'sd256 - w1;
    lsum = lp * w0 + lq * w1;
    // round to nearest, ties toward plus infinity
    lrnd = (lsum + 53'sd32768) >>> 16;
  end

  // blend partials and result registers
  always_ff @(posedge clk) begin
    if (cmd.lerp_en) begin
      case (cmd.lerp_step)
        vgbs_pkg::LS_TOPX: topx  <= lsum[41:0];
        vgbs_pkg::LS_TOPY: topy  <= lsum[41:0];
        vgbs_pkg::LS_BOTX: botx  <= lsum[41:0];
        vgbs_pkg::LS_BOTY: boty  <= lsum[41:0];
        vgbs_pkg::LS_RX: begin
          res_x  <= lrnd[31:0];
          res_st <= vgbs_pkg::ST_OK;
        end
        vgbs_pkg::LS_RY: res_y <= lrnd[31:0];
        default: topx <= lsum[41:0];
      endcase
    end else begin
      case (cmd.res_op)
        vgbs_pkg::RES_OK: begin
          res_x <= '0; res_y <= '0; res_st <= vgbs_pkg::ST_OK;
        end
        vgbs_pkg::RES_EMPTY: begin
          res_x <= '0; res_y <= '0; res_st <= vgbs_pkg::ST_EMPTY;
        end
        vgbs_pkg::RES_OOB: begin
          res_x <= '0; res_y <= '0; res_st <= vgbs_pkg::ST_OOB;
        end
        vgbs_pkg::RES_READ: begin
          res_x  <= cell_a[31:0];
          res_y  <= cell_a[63:32];
          res_st <= vgbs_pkg::ST_OK;
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      result_x <= res_x;
      result_y <= res_y;
      status   <= res_st;
    end
  end

  // status to controller
  assign sts.act      = act;
  assign sts.empty    = empty;
  assign sts.oob      = oob;
  assign sts.clr_last = (clr_addr == LAST_CELL);
  assign sts.out_free = !out_valid || !out_stall;

endmodule

@@ sv/vector_grid_bilinear_sampler_unit.sv @@
// sequence: write, empty and out-of-range go from decode straight to the result register;
//   read takes one store read; bilinear sample takes four reads on the single store port,
//   then six passes through the one shared blend unit; clear runs a sweep over every cell
// throughput: one item at a time; the next beat is taken once the result is loaded into the output register
// reset: synchronous; size registers go to 128 and a sweep zeroes the store,
//   with in_stall high
module vector_grid_bilinear_sampler_unit #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [31:0] value_x,
  input  logic signed [31:0] value_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] result_x,
  output logic signed [31:0] result_y,
  output logic [1:0]         status
);

  vgbs_pkg::cmd_t cmd;
  vgbs_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  // sequencer
  vgbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // store, address and blend datapath
  vgbs_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .action    (action),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .value_x   (value_x),
    .value_y   (value_y),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .result_x  (result_x),
    .result_y  (result_y),
    .status    (status)
  );

endmodule

@@ sim/tb_vector_grid_bilinear_sampler_unit.sv @@
`timescale 1ns / 1ps

module tb_vector_grid_bilinear_sampler_unit;

  localparam int MAXW  = 128;
  localparam int MAXH  = 128;
  localparam int CELLS = MAXW * MAXH;

  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic [1:0]         st;
  } vec_result_t;

  // grid model and expected result queue
  class grid_scoreboard;
    logic [63:0]   cells [CELLS];
    int unsigned   width_reg;
    int unsigned   height_reg;
    vec_result_t   pending [$];
    int            errors;

    function void reset_grid();
      for (int i = 0; i < CELLS; i++) cells[i] = '0;
      width_reg  = 128;
      height_reg = 128;
      pending.delete();
      errors = 0;
    endfunction

    function void set_reg(logic [7:0] idx, logic [7:0] data);
      if (idx == vgbs_pkg::REG_WIDTH) width_reg = data;
      else if (idx == vgbs_pkg::REG_HEIGHT) height_reg = data;
    endfunction

    function longint blend(longint a, longint b, int unsigned t);
      return a * longint'(256 - t) + b * longint'(t);
    endfunction

    function longint round_q16(longint s);
      return (s + 32768) >>> 16;
    endfunction

    function logic [63:0] fetch(int unsigned idx);
      return idx < CELLS ? cells[idx] : 64'd0;
    endfunction

    // work out the result of one accepted beat
    function void note_input(logic [1:0] act, logic signed [15:0] px,
                             logic signed [15:0] py, logic [31:0] vx, logic [31:0] vy);
      vec_result_t r;
      int unsigned w, h, cx, cy, x0, y0, x1, y1, tx, ty, top, idx;
      logic [63:0] a, b, c, d;
      longint tpx, bpx, tpy, bpy;
      w = width_reg > MAXW ? MAXW : width_reg;
      h = height_reg > MAXH ? MAXH : height_reg;
      r = '0;
      r.st = vgbs_pkg::ST_OK;
      if (act == vgbs_pkg::ACT_CLEAR) begin
        for (int i = 0; i < CELLS; i++) cells[i] = '0;
      end else if (w == 0 || h == 0) begin
        r.st = vgbs_pkg::ST_EMPTY;
      end else if (act == vgbs_pkg::ACT_WRITE || act == vgbs_pkg::ACT_READ) begin
        if (px < 0 || py < 0 || (int'(px) >> 8) >= w || (int'(py) >> 8) >= h) begin
          r.st = vgbs_pkg::ST_OOB;
        end else begin
          idx = (int'(py) >> 8) * w + (int'(px) >> 8);
          if (idx < CELLS) begin
            if (act == vgbs_pkg::ACT_WRITE) cells[idx] = {vy, vx};
            else begin
              r.rx = cells[idx][31:0];
              r.ry = cells[idx][63:32];
            end
          end
        end
      end else begin
        top = (w - 1) * 256;
        cx = px < 0 ? 0 : (int'(px) > top ? top : int'(px));
        top = (h - 1) * 256;
        cy = py < 0 ? 0 : (int'(py) > top ? top : int'(py));
        x0 = cx >> 8; y0 = cy >> 8; tx = cx & 255; ty = cy & 255;
        x1 = x0 + 1 < w ? x0 + 1 : w - 1;
        y1 = y0 + 1 < h ? y0 + 1 : h - 1;
        a = fetch(y0 * w + x0); b = fetch(y0 * w + x1);
        c = fetch(y1 * w + x0); d = fetch(y1 * w + x1);
        tpx = blend(longint'($signed(a[31:0])), longint'($signed(b[31:0])), tx);
        bpx = blend(longint'($signed(c[31:0])), longint'($signed(d[31:0])), tx);
        tpy = blend(longint'($signed(a[63:32])), longint'($signed(b[63:32])), tx);
        bpy = blend(longint'($signed(c[63:32])), longint'($signed(d[63:32])), tx);
        r.rx = 32'(round_q16(blend(tpx, bpx, ty)));
        r.ry = 32'(round_q16(blend(tpy, bpy, ty)));
      end
      pending.push_back(r);
    endfunction

    // compare one result beat with the oldest expectation
    function void check_result(logic signed [31:0] rx, logic signed [31:0] ry, logic [1:0] st);
      vec_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat x=%0d y=%0d status=%0d", $time, rx, ry, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (rx !== e.rx) begin
        $display("%0t: result_x expected %0d actual %0d", $time, e.rx, rx);
        errors++;
      end
      if (ry !== e.ry) begin
        $display("%0t: result_y expected %0d actual %0d", $time, e.ry, ry);
        errors++;
      end
      if (st !== e.st) begin
        $display("%0t: status expected %0d actual %0d", $time, e.st, st);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [7:0]         cfg_index = '0;
  logic [7:0]         cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         action = '0;
  logic signed [15:0] pos_x = '0;
  logic signed [15:0] pos_y = '0;
  logic signed [31:0] value_x = '0;
  logic signed [31:0] value_y = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] result_x;
  logic signed [31:0] result_y;
  logic [1:0]         status;

  grid_scoreboard grid_sb;
  bit             calm = 1'b0;

  vector_grid_bilinear_sampler_unit #(.MAX_WIDTH(MAXW), .MAX_HEIGHT(MAXH)) dut (.*);

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver side: random stall and result check
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) grid_sb.check_result(result_x, result_y, status);
      out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 6);
    end
  end

  // timeout
  initial begin
    #400ms;
    $display("tb: failure");
    $finish;
  end

  task automatic write_reg(logic [7:0] idx, logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    grid_sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_beat(logic [1:0] act, logic signed [15:0] px, logic signed [15:0] py,
                           logic [31:0] vx, logic [31:0] vy);
    while (!calm && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    pos_x    <= px;
    pos_y    <= py;
    value_x  <= vx;
    value_y  <= vy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    grid_sb.note_input(act, px, py, vx, vy);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (grid_sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // coordinate inside the grid or up to one cell past it, sometimes anywhere
  function automatic logic signed [15:0] pick_pos(int unsigned n);
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return 16'($urandom_range(0, (n + 1) * 256 - 1));
  endfunction

  task automatic random_phase(int unsigned count, int unsigned w, int unsigned h);
    int unsigned r;
    logic [1:0]  act;
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 2 && i < count / 2 + 60);
      r = $urandom_range(0, 99);
      act = r < 40 ? vgbs_pkg::ACT_WRITE :
            (r < 60 ? vgbs_pkg::ACT_READ :
            (r < 99 ? vgbs_pkg::ACT_SAMPLE : vgbs_pkg::ACT_CLEAR));
      send_beat(act, pick_pos(w), pick_pos(h), $urandom, $urandom);
    end
    calm = 1'b0;
  endtask

  initial begin
    int unsigned widths [6]  = '{128, 5, 1, 200, 17, 0};
    int unsigned heights [6] = '{128, 3, 1, 255, 1, 9};
    grid_sb = new();
    grid_sb.reset_grid();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every action, clamps, edges
    send_beat(vgbs_pkg::ACT_READ, 16'sd0, 16'sd0, '0, '0);
    send_beat(vgbs_pkg::ACT_WRITE, 16'sd0, 16'sd0, 32'h7fffffff, 32'h80000000);
    send_beat(vgbs_pkg::ACT_WRITE, 16'sh0100, 16'sd0, 32'h80000000, 32'h7fffffff);
    send_beat(vgbs_pkg::ACT_WRITE, 16'sd0, 16'sh0100, 32'hffffffff, 32'h00000001);
    send_beat(vgbs_pkg::ACT_WRITE, 16'sh0100, 16'sh0100, 32'h00000001, 32'hffffffff);
    send_beat(vgbs_pkg::ACT_WRITE, 16'sh7f80, 16'sh7fff, 32'h12345678, 32'h9abcdef0);
    send_beat(vgbs_pkg::ACT_READ, 16'sh7fff, 16'sh7fff, '0, '0);
    send_beat(vgbs_pkg::ACT_READ, 16'sh8000, 16'sd0, '0, '0);
    send_beat(vgbs_pkg::ACT_WRITE, 16'sd0, -16'sd1, '1, '1);
    send_beat(vgbs_pkg::ACT_READ, 16'sh0100, 16'sh0000, '0, '0);
    send_beat(vgbs_pkg::ACT_SAMPLE, 16'sh0080, 16'sh0080, '0, '0);
    send_beat(vgbs_pkg::ACT_SAMPLE, 16'sh00ff, 16'sh00ff, '0, '0);
    send_beat(vgbs_pkg::ACT_SAMPLE, 16'sh8000, 16'sh8000, '0, '0);
    send_beat(vgbs_pkg::ACT_SAMPLE, 16'sh7fff, 16'sh7fff, '0, '0);
    send_beat(vgbs_pkg::ACT_SAMPLE, 16'sh7f40, 16'sh7fc0, '0, '0);
    send_beat(vgbs_pkg::ACT_CLEAR, 16'sh5555, 16'shaaaa, 32'h55555555, 32'haaaaaaaa);
    send_beat(vgbs_pkg::ACT_READ, 16'sd0, 16'sd0, '0, '0);
    send_beat(vgbs_pkg::ACT_SAMPLE, 16'sh0080, 16'sh0040, '0, '0);
    drain();

    // random phases across grid sizes
    for (int p = 0; p < 6; p++) begin
      write_reg(vgbs_pkg::REG_WIDTH, 8'(widths[p]));
      write_reg(vgbs_pkg::REG_HEIGHT, 8'(heights[p]));
      if (p == 5) send_beat(vgbs_pkg::ACT_READ, 16'sd0, 16'sd0, '0, '0);
      send_beat(vgbs_pkg::ACT_CLEAR, 16'($urandom), 16'($urandom), $urandom, $urandom);
      random_phase(p == 0 ? 400 : 220, widths[p] > MAXW ? MAXW : widths[p],
                   heights[p] > MAXH ? MAXH : heights[p]);
      drain();
    end
    write_reg(vgbs_pkg::REG_WIDTH, 8'd255);
    write_reg(vgbs_pkg::REG_HEIGHT, 8'd0);
    random_phase(20, 128, 1);
    drain();

    if (grid_sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

@@ vector_grid_bilinear_sampler_unit.f @@
sv/vgbs_pkg.sv
sv/vgbs_ctrl.sv
sv/vgbs_dp.sv
sv/vector_grid_bilinear_sampler_unit.sv
sim/tb_vector_grid_bilinear_sampler_unit.sv
